### rtl/gradient_noise_2d_octaves_defines.svh
// Assertion macros used by the top-level RTL file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GRADIENT_NOISE_2D_OCTAVES_DEFINES_SVH
`define GRADIENT_NOISE_2D_OCTAVES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GN2O_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GN2O_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gn2o_pkg.sv
package gn2o_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int TABLE_AW        = 8;
    localparam int TABLE_DW        = 8;
    localparam int MAX_OCTAVES_DEF = 8;

    localparam int COORD_W = 16;
    localparam int FREQ_W  = 16;
    localparam int COUNT_W = 4;
    localparam int NOISE_W = 16;
    localparam int POS_W   = 28;
    localparam int FRAC_W  = 16;
    localparam int FADE_W  = 17;
    localparam int GRAD_W  = 19;
    localparam int DIFF_W  = 20;
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int IN_DATA_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ     = 2'd1;

    localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 4'd4;
    localparam logic [FREQ_W-1:0]  BASE_FREQ_RST    = 16'd2048;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [NOISE_W-1:0] NOISE_POS_MAX = 16'h7FFF;
    localparam logic [NOISE_W-1:0] NOISE_NEG_MAX = 16'h8000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRE_X,
        ST_PRE_Y,
        ST_PRE_END,
        ST_FX2,
        ST_FX3,
        ST_FX4,
        ST_FX5,
        ST_FXF,
        ST_FY3,
        ST_FY4,
        ST_FY5,
        ST_FYF,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4,
        ST_L5,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    // Quintic fade 6t^5 - 15t^4 + 10t^3 from the truncated powers, clamped to [0, 1.0].
    function automatic logic [FADE_W-1:0] fade_q16(input logic [FRAC_W-1:0] t3,
                                                   input logic [FRAC_W-1:0] t4,
                                                   input logic [FRAC_W-1:0] t5);
        logic signed [22:0] e3;
        logic signed [22:0] e4;
        logic signed [22:0] e5;
        logic signed [22:0] f;
        logic [FADE_W-1:0]  r;
        e3 = signed'({7'd0, t3});
        e4 = signed'({7'd0, t4});
        e5 = signed'({7'd0, t5});
        f  = (e5 <<< 2) + (e5 <<< 1) - ((e4 <<< 4) - e4) + (e3 <<< 3) + (e3 <<< 1);
        if (f[22])
        begin
            r = '0;
        end
        else if (f > 23'sd65536)
        begin
            r = 17'h10000;
        end
        else
        begin
            r = f[FADE_W-1:0];
        end
        return r;
    endfunction

    // Diagonal gradients selected by the two low hash bits.
    function automatic logic signed [GRAD_W-1:0] grad(input logic [1:0] h,
                                                      input logic signed [GRAD_W-1:0] dx,
                                                      input logic signed [GRAD_W-1:0] dy);
        logic signed [GRAD_W-1:0] g;
        case (h)
            2'd0:    g = dx + dy;
            2'd1:    g = dx - dy;
            2'd2:    g = -dx - dy;
            default: g = dy - dx;
        endcase
        return g;
    endfunction

endpackage

### rtl/gn2o_ram.sv
module gn2o_ram #(
    parameter int WIDTH = gn2o_pkg::TABLE_DW,
    parameter int DEPTH = gn2o_pkg::TABLE_SIZE
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gn2o_mul.sv
module gn2o_mul (
    input  logic                                clk,
    input  logic signed [gn2o_pkg::MUL_A_W-1:0] a,
    input  logic signed [gn2o_pkg::MUL_B_W-1:0] b,
    output logic signed [gn2o_pkg::MUL_P_W-1:0] prod
);

    logic signed [gn2o_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= gn2o_pkg::MUL_P_W'(a) * gn2o_pkg::MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

### rtl/gn2o_div.sv
module gn2o_div #(
    parameter int DVD_W = gn2o_pkg::GRAD_W + gn2o_pkg::MAX_OCTAVES_DEF,
    parameter int DVS_W = gn2o_pkg::MAX_OCTAVES_DEF + 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic             last_step;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign last_step = (cnt_reg == CNT_W'(DVD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/gradient_noise_2d_octaves.sv
// Two-dimensional fractal gradient noise over a loadable 256-entry permutation table.
// Input items arrive on the s_ stream. With s_tuser low an item writes one table
// entry and the block stays idle. With s_tuser high the item evaluates noise at
// the Q8.8 point in s_tdata and produces one Q2.13 result on the m_ stream.
// Registers are written through the cfg_ channel at any time; cfg_ready is always
// high, but writes should only be made while no evaluation is under way.
// An evaluation works through its octaves one after another; each octave runs
// fourteen steps on the one shared multiplier, which does the fade powers and
// the three lerps in turn, and the final normalization runs one quotient bit per
// cycle through a serial divider. s_tready is high only while the block is idle,
// so one item is worked on at a time, and the next item can be taken at the earliest
// in the same cycle that the earlier result appears.
// A finished result sits in the output register; the block accepts
// the next item while it waits, and only holds a later result until the receiver
// has taken the earlier one. Reset clears the control state and sets the octave
// count to 4 and the base frequency to 0.5; the permutation table keeps no reset
// value and must be loaded in full before the first evaluation.
`include "gradient_noise_2d_octaves_defines.svh"

module gradient_noise_2d_octaves #(
    parameter int MAX_OCTAVES = gn2o_pkg::MAX_OCTAVES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // table_index [7:0], table_value [15:8], x_coord [31:16], y_coord [47:32]
    input  logic [gn2o_pkg::IN_DATA_W-1:0]    s_tdata,
    // action [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // noise_value [15:0]
    output logic [gn2o_pkg::NOISE_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gn2o_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gn2o_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int N_W   = $clog2(MAX_OCTAVES + 1);
    localparam int NUM_W = gn2o_pkg::GRAD_W + MAX_OCTAVES;
    localparam int DEN_W = MAX_OCTAVES + 3;

    gn2o_pkg::state_t state_reg;
    gn2o_pkg::state_t state_next;

    logic [gn2o_pkg::COUNT_W-1:0]        oct_cnt_reg;
    logic [gn2o_pkg::FREQ_W-1:0]         base_freq_reg;
    logic signed [gn2o_pkg::COORD_W-1:0] x_reg;
    logic signed [gn2o_pkg::COORD_W-1:0] y_reg;
    logic [gn2o_pkg::POS_W-1:0]          ux_reg;
    logic [gn2o_pkg::POS_W-1:0]          uy_reg;
    logic [N_W-1:0]                      n_reg;
    logic [N_W-1:0]                      k_reg;
    logic [N_W-1:0]                      n_clamp;
    logic signed [NUM_W-1:0]             num_reg;
    logic                                neg_reg;
    logic [gn2o_pkg::TABLE_DW-1:0]       p0_reg;
    logic [gn2o_pkg::TABLE_DW-1:0]       p1_reg;
    logic [1:0]                          h_aa_reg;
    logic [1:0]                          h_ab_reg;
    logic [1:0]                          h_ba_reg;
    logic [1:0]                          h_bb_reg;
    logic [gn2o_pkg::FRAC_W-1:0]         t3_reg;
    logic [gn2o_pkg::FRAC_W-1:0]         t4_reg;
    logic [gn2o_pkg::FADE_W-1:0]         u_reg;
    logic [gn2o_pkg::FADE_W-1:0]         v_reg;
    logic signed [gn2o_pkg::GRAD_W-1:0]  g_aa_reg;
    logic signed [gn2o_pkg::GRAD_W-1:0]  g_ab_reg;
    logic signed [gn2o_pkg::GRAD_W-1:0]  g_ba_reg;
    logic signed [gn2o_pkg::GRAD_W-1:0]  g_bb_reg;
    logic signed [gn2o_pkg::GRAD_W-1:0]  x1_reg;
    logic signed [gn2o_pkg::GRAD_W-1:0]  x2_reg;
    logic                                m_tvalid_reg;
    logic [gn2o_pkg::NOISE_W-1:0]        m_tdata_reg;

    logic signed [gn2o_pkg::MUL_A_W-1:0] mul_a;
    logic signed [gn2o_pkg::MUL_B_W-1:0] mul_b;
    logic signed [gn2o_pkg::MUL_P_W-1:0] mul_p;

    logic                                ram_we;
    logic [gn2o_pkg::TABLE_AW-1:0]       ram_raddr;
    logic [gn2o_pkg::TABLE_DW-1:0]       ram_rdata;

    logic                                div_start;
    logic                                div_done;
    logic [NUM_W-1:0]                    div_quo;
    logic [NUM_W-1:0]                    num_mag;
    logic [DEN_W-1:0]                    den;

    logic                                s_accept;
    logic                                eval_accept;
    logic                                out_load;
    logic                                last_oct;
    logic [gn2o_pkg::TABLE_AW-1:0]       xi;
    logic [gn2o_pkg::TABLE_AW-1:0]       yi;
    logic [gn2o_pkg::FRAC_W-1:0]         xf;
    logic [gn2o_pkg::FRAC_W-1:0]         yf;
    logic [gn2o_pkg::FRAC_W-1:0]         pw;
    logic signed [gn2o_pkg::GRAD_W-1:0]  lerp_add;
    logic signed [gn2o_pkg::GRAD_W-1:0]  oct_val;
    logic signed [gn2o_pkg::GRAD_W-1:0]  dx0;
    logic signed [gn2o_pkg::GRAD_W-1:0]  dx1;
    logic signed [gn2o_pkg::GRAD_W-1:0]  dy0;
    logic signed [gn2o_pkg::GRAD_W-1:0]  dy1;
    logic signed [gn2o_pkg::DIFF_W-1:0]  diff_a;
    logic signed [gn2o_pkg::DIFF_W-1:0]  diff_b;
    logic signed [gn2o_pkg::DIFF_W-1:0]  diff_x;
    logic [gn2o_pkg::NOISE_W-1:0]        sat_val;

    assign s_tready    = (state_reg == gn2o_pkg::ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign s_accept    = s_tvalid && s_tready;
    assign eval_accept = s_accept && (s_tuser == gn2o_pkg::ACT_EVAL);
    assign ram_we      = s_accept && (s_tuser == gn2o_pkg::ACT_LOAD);
    assign out_load    = (state_reg == gn2o_pkg::ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign last_oct    = (({1'b0, k_reg} + 1'b1) == {1'b0, n_reg});

    assign xi = ux_reg[27:20];
    assign yi = uy_reg[27:20];
    assign xf = ux_reg[19:4];
    assign yf = uy_reg[19:4];
    assign pw = mul_p[31:16];

    assign lerp_add = mul_p[34:16];
    assign oct_val  = x1_reg + lerp_add;

    assign dx0 = signed'({3'd0, xf});
    assign dy0 = signed'({3'd0, yf});
    assign dx1 = dx0 - 19'sd65536;
    assign dy1 = dy0 - 19'sd65536;

    assign diff_a = gn2o_pkg::DIFF_W'(g_ab_reg) - gn2o_pkg::DIFF_W'(g_aa_reg);
    assign diff_b = gn2o_pkg::DIFF_W'(g_bb_reg) - gn2o_pkg::DIFF_W'(g_ba_reg);
    assign diff_x = gn2o_pkg::DIFF_W'(x2_reg) - gn2o_pkg::DIFF_W'(x1_reg);

    assign num_mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign div_start = (state_reg == gn2o_pkg::ST_DIV_GO);

    always_comb
    begin
        if (oct_cnt_reg == '0)
        begin
            n_clamp = N_W'(1);
        end
        else if (int'(oct_cnt_reg) > MAX_OCTAVES)
        begin
            n_clamp = N_W'(MAX_OCTAVES);
        end
        else
        begin
            n_clamp = N_W'(oct_cnt_reg);
        end
    end

    // The divisor is (2^n - 1) * 8.
    always_comb
    begin
        den = '0;
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            den[i + 3] = (i < int'(n_reg));
        end
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            sat_val = (div_quo > NUM_W'(gn2o_pkg::NOISE_POS_MAX)) ?
                      gn2o_pkg::NOISE_POS_MAX : div_quo[gn2o_pkg::NOISE_W-1:0];
        end
        else
        begin
            sat_val = (div_quo > NUM_W'(gn2o_pkg::NOISE_NEG_MAX)) ?
                      gn2o_pkg::NOISE_NEG_MAX : (~div_quo[gn2o_pkg::NOISE_W-1:0] + 1'b1);
        end
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        ram_raddr = yi;
        case (state_reg)
            gn2o_pkg::ST_PRE_X:
            begin
                mul_a = gn2o_pkg::MUL_A_W'(x_reg);
                mul_b = signed'({5'd0, base_freq_reg});
            end
            gn2o_pkg::ST_PRE_Y:
            begin
                mul_a = gn2o_pkg::MUL_A_W'(y_reg);
                mul_b = signed'({5'd0, base_freq_reg});
            end
            gn2o_pkg::ST_FX2:
            begin
                mul_a     = signed'({2'd0, xf});
                mul_b     = signed'({5'd0, xf});
                ram_raddr = yi;
            end
            gn2o_pkg::ST_FX3:
            begin
                mul_a     = signed'({2'd0, pw});
                mul_b     = signed'({5'd0, xf});
                ram_raddr = yi + 1'b1;
            end
            gn2o_pkg::ST_FX4:
            begin
                mul_a     = signed'({2'd0, pw});
                mul_b     = signed'({5'd0, xf});
                ram_raddr = xi + p0_reg;
            end
            gn2o_pkg::ST_FX5:
            begin
                mul_a     = signed'({2'd0, pw});
                mul_b     = signed'({5'd0, xf});
                ram_raddr = xi + p1_reg;
            end
            gn2o_pkg::ST_FXF:
            begin
                mul_a     = signed'({2'd0, yf});
                mul_b     = signed'({5'd0, yf});
                ram_raddr = xi + 1'b1 + p0_reg;
            end
            gn2o_pkg::ST_FY3:
            begin
                mul_a     = signed'({2'd0, pw});
                mul_b     = signed'({5'd0, yf});
                ram_raddr = xi + 1'b1 + p1_reg;
            end
            gn2o_pkg::ST_FY4, gn2o_pkg::ST_FY5:
            begin
                mul_a = signed'({2'd0, pw});
                mul_b = signed'({5'd0, yf});
            end
            gn2o_pkg::ST_L1:
            begin
                mul_a = signed'({1'b0, v_reg});
                mul_b = gn2o_pkg::MUL_B_W'(diff_a);
            end
            gn2o_pkg::ST_L2:
            begin
                mul_a = signed'({1'b0, v_reg});
                mul_b = gn2o_pkg::MUL_B_W'(diff_b);
            end
            gn2o_pkg::ST_L4:
            begin
                mul_a = signed'({1'b0, u_reg});
                mul_b = gn2o_pkg::MUL_B_W'(diff_x);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gn2o_pkg::ST_IDLE:
            begin
                if (eval_accept)
                begin
                    state_next = gn2o_pkg::ST_PRE_X;
                end
            end
            gn2o_pkg::ST_PRE_X:    state_next = gn2o_pkg::ST_PRE_Y;
            gn2o_pkg::ST_PRE_Y:    state_next = gn2o_pkg::ST_PRE_END;
            gn2o_pkg::ST_PRE_END:  state_next = gn2o_pkg::ST_FX2;
            gn2o_pkg::ST_FX2:      state_next = gn2o_pkg::ST_FX3;
            gn2o_pkg::ST_FX3:      state_next = gn2o_pkg::ST_FX4;
            gn2o_pkg::ST_FX4:      state_next = gn2o_pkg::ST_FX5;
            gn2o_pkg::ST_FX5:      state_next = gn2o_pkg::ST_FXF;
            gn2o_pkg::ST_FXF:      state_next = gn2o_pkg::ST_FY3;
            gn2o_pkg::ST_FY3:      state_next = gn2o_pkg::ST_FY4;
            gn2o_pkg::ST_FY4:      state_next = gn2o_pkg::ST_FY5;
            gn2o_pkg::ST_FY5:      state_next = gn2o_pkg::ST_FYF;
            gn2o_pkg::ST_FYF:      state_next = gn2o_pkg::ST_L1;
            gn2o_pkg::ST_L1:       state_next = gn2o_pkg::ST_L2;
            gn2o_pkg::ST_L2:       state_next = gn2o_pkg::ST_L3;
            gn2o_pkg::ST_L3:       state_next = gn2o_pkg::ST_L4;
            gn2o_pkg::ST_L4:       state_next = gn2o_pkg::ST_L5;
            gn2o_pkg::ST_L5:
            begin
                state_next = last_oct ? gn2o_pkg::ST_DIV_GO : gn2o_pkg::ST_FX2;
            end
            gn2o_pkg::ST_DIV_GO:   state_next = gn2o_pkg::ST_DIV_WAIT;
            gn2o_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = gn2o_pkg::ST_FINISH;
                end
            end
            gn2o_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = gn2o_pkg::ST_IDLE;
                end
            end
            default:               state_next = gn2o_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gn2o_pkg::ST_IDLE;
            oct_cnt_reg   <= gn2o_pkg::OCTAVE_COUNT_RST;
            base_freq_reg <= gn2o_pkg::BASE_FREQ_RST;
            n_reg         <= N_W'(1);
            k_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gn2o_pkg::CFG_OCTAVE_COUNT: oct_cnt_reg   <= cfg_data[gn2o_pkg::COUNT_W-1:0];
                    gn2o_pkg::CFG_BASE_FREQ:    base_freq_reg <= cfg_data[gn2o_pkg::FREQ_W-1:0];
                    default:                    oct_cnt_reg   <= oct_cnt_reg;
                endcase
            end
            if (eval_accept)
            begin
                n_reg <= n_clamp;
                k_reg <= '0;
            end
            else if ((state_reg == gn2o_pkg::ST_L5) && !last_oct)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_accept)
        begin
            x_reg   <= s_tdata[31:16];
            y_reg   <= s_tdata[47:32];
            num_reg <= '0;
        end
        if (out_load)
        begin
            m_tdata_reg <= sat_val;
        end
        case (state_reg)
            gn2o_pkg::ST_PRE_Y:   ux_reg <= mul_p[gn2o_pkg::POS_W-1:0];
            gn2o_pkg::ST_PRE_END: uy_reg <= mul_p[gn2o_pkg::POS_W-1:0];
            gn2o_pkg::ST_FX3:     p0_reg <= ram_rdata;
            gn2o_pkg::ST_FX4:
            begin
                t3_reg <= pw;
                p1_reg <= ram_rdata;
            end
            gn2o_pkg::ST_FX5:
            begin
                t4_reg   <= pw;
                h_aa_reg <= ram_rdata[1:0];
            end
            gn2o_pkg::ST_FXF:
            begin
                u_reg    <= gn2o_pkg::fade_q16(t3_reg, t4_reg, pw);
                h_ab_reg <= ram_rdata[1:0];
            end
            gn2o_pkg::ST_FY3:     h_ba_reg <= ram_rdata[1:0];
            gn2o_pkg::ST_FY4:
            begin
                t3_reg   <= pw;
                h_bb_reg <= ram_rdata[1:0];
            end
            gn2o_pkg::ST_FY5:     t4_reg <= pw;
            gn2o_pkg::ST_FYF:
            begin
                v_reg    <= gn2o_pkg::fade_q16(t3_reg, t4_reg, pw);
                g_aa_reg <= gn2o_pkg::grad(h_aa_reg, dx0, dy0);
                g_ab_reg <= gn2o_pkg::grad(h_ab_reg, dx0, dy1);
                g_ba_reg <= gn2o_pkg::grad(h_ba_reg, dx1, dy0);
                g_bb_reg <= gn2o_pkg::grad(h_bb_reg, dx1, dy1);
            end
            gn2o_pkg::ST_L2:      x1_reg <= g_aa_reg + lerp_add;
            gn2o_pkg::ST_L3:      x2_reg <= g_ba_reg + lerp_add;
            gn2o_pkg::ST_L5:
            begin
                num_reg <= (num_reg <<< 1)
                           + {{(NUM_W - gn2o_pkg::GRAD_W){oct_val[gn2o_pkg::GRAD_W-1]}}, oct_val};
                ux_reg  <= {ux_reg[gn2o_pkg::POS_W-2:0], 1'b0};
                uy_reg  <= {uy_reg[gn2o_pkg::POS_W-2:0], 1'b0};
            end
            gn2o_pkg::ST_DIV_GO:  neg_reg <= num_reg[NUM_W-1];
            default:              neg_reg <= neg_reg;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    gn2o_ram #(
        .WIDTH (gn2o_pkg::TABLE_DW),
        .DEPTH (gn2o_pkg::TABLE_SIZE)
    ) u_perm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_tdata[7:0]),
        .wdata (s_tdata[15:8]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gn2o_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    gn2o_div #(
        .DVD_W (NUM_W),
        .DVS_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_quo)
    );

    `GN2O_ASSERT_NXT(a_eval_starts, eval_accept, state_reg == gn2o_pkg::ST_PRE_X, "evaluate transfer did not start the sequencer")
    `GN2O_ASSERT_IMP(a_result_from_finish, $rose(m_tvalid_reg), $past(state_reg) == gn2o_pkg::ST_FINISH, "result appeared outside the finish step")
    `GN2O_ASSERT_IMP(a_octave_in_range, state_reg != gn2o_pkg::ST_IDLE, (k_reg < n_reg) && (n_reg != '0), "octave index out of range")
    `GN2O_ASSERT_IMP(a_div_done_waited, div_done, state_reg == gn2o_pkg::ST_DIV_WAIT, "divider finished while the sequencer was not waiting")

endmodule

### bench/gn2o_noise_checker.sv
`timescale 1ns / 100ps

module gn2o_noise_checker
    import gn2o_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [NOISE_W-1:0]      m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      failures,
    output int                      outstanding
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [NOISE_W-1:0] noise;
    } noise_due_t;

    logic [TABLE_DW-1:0] perm [0:TABLE_SIZE-1];
    logic [COUNT_W-1:0]  octaves;
    logic [FREQ_W-1:0]   freq;
    noise_due_t          noise_due [$];
    noise_due_t          head;

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    function automatic longint fade_curve(input longint t);
        longint t2;
        longint t3;
        longint t4;
        longint t5;
        longint f;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        t4 = (t3 * t) >>> 16;
        t5 = (t4 * t) >>> 16;
        f  = 6 * t5 - 15 * t4 + 10 * t3;
        if (f < 0)
        begin
            f = 0;
        end
        if (f > 65536)
        begin
            f = 65536;
        end
        return f;
    endfunction

    // The arithmetic shift of a signed product is the floor division by 2^16.
    function automatic longint blend(input longint a, input longint b, input longint t);
        return a + ((t * (b - a)) >>> 16);
    endfunction

    function automatic longint corner_slope(input logic [7:0] h, input longint dx,
                                            input longint dy);
        longint g;
        case (h[1:0])
            2'd0:    g = dx + dy;
            2'd1:    g = dx - dy;
            2'd2:    g = -dx - dy;
            default: g = dy - dx;
        endcase
        return g;
    endfunction

    function automatic longint octave_value(input longint px, input longint py, input int k);
        logic [63:0]         ux;
        logic [63:0]         uy;
        logic [TABLE_AW-1:0] xi;
        logic [TABLE_AW-1:0] yi;
        logic [TABLE_AW-1:0] xi1;
        logic [TABLE_AW-1:0] yi1;
        logic [TABLE_AW-1:0] idx;
        logic [TABLE_DW-1:0] ha;
        logic [TABLE_DW-1:0] hb;
        logic [TABLE_DW-1:0] hc;
        logic [TABLE_DW-1:0] hd;
        longint              xf;
        longint              yf;
        longint              u;
        longint              v;
        longint              lo;
        longint              hi;
        ux  = px << k;
        uy  = py << k;
        xi  = ux[27:20];
        yi  = uy[27:20];
        xi1 = xi + 8'd1;
        yi1 = yi + 8'd1;
        xf  = longint'({48'd0, ux[19:4]});
        yf  = longint'({48'd0, uy[19:4]});
        idx = xi + perm[yi];
        ha  = perm[idx];
        idx = xi + perm[yi1];
        hb  = perm[idx];
        idx = xi1 + perm[yi];
        hc  = perm[idx];
        idx = xi1 + perm[yi1];
        hd  = perm[idx];
        u   = fade_curve(xf);
        v   = fade_curve(yf);
        lo  = blend(corner_slope(ha, xf, yf), corner_slope(hb, xf, yf - 65536), v);
        hi  = blend(corner_slope(hc, xf - 65536, yf),
                    corner_slope(hd, xf - 65536, yf - 65536), v);
        return blend(lo, hi, u);
    endfunction

    function automatic logic [NOISE_W-1:0] predict_noise(input logic [COORD_W-1:0] x,
                                                         input logic [COORD_W-1:0] y);
        int     n;
        longint px;
        longint py;
        longint num;
        longint den;
        longint q;
        n = octaves;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_OCTAVES_DEF)
        begin
            n = MAX_OCTAVES_DEF;
        end
        px  = longint'($signed(x)) * longint'({48'd0, freq});
        py  = longint'($signed(y)) * longint'({48'd0, freq});
        num = 0;
        for (int k = 0; k < n; k++)
        begin
            num += octave_value(px, py, k) * (longint'(1) << (n - 1 - k));
        end
        den = ((longint'(1) << n) - 1) * 8;
        q   = num / den;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return 16'(q);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves = OCTAVE_COUNT_RST;
            freq    = BASE_FREQ_RST;
            noise_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OCTAVE_COUNT)
                begin
                    octaves = cfg_data[COUNT_W-1:0];
                end
                else if (cfg_index == CFG_BASE_FREQ)
                begin
                    freq = cfg_data;
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_LOAD)
                begin
                    perm[s_tdata[7:0]] = s_tdata[15:8];
                end
                else
                begin
                    head.x     = s_tdata[31:16];
                    head.y     = s_tdata[47:32];
                    head.noise = predict_noise(s_tdata[31:16], s_tdata[47:32]);
                    noise_due.push_back(head);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (noise_due.size() == 0)
                begin
                    failures++;
                    $display("%0t: noise_value transfer %0d with no result expected",
                             $time, $signed(m_tdata));
                end
                else
                begin
                    head = noise_due.pop_front();
                    if (m_tdata !== head.noise)
                    begin
                        failures++;
                        $display("%0t: noise_value at (%0d, %0d) expected %0d, actual %0d",
                                 $time, $signed(head.x), $signed(head.y),
                                 $signed(head.noise), $signed(m_tdata));
                    end
                end
            end
        end
        outstanding = noise_due.size();
    end

endmodule

### bench/tb_gradient_noise_2d_octaves.sv
`timescale 1ns / 100ps

module tb_gradient_noise_2d_octaves;

    import gn2o_pkg::*;

    localparam int     IDLE_PCT      = 21;
    localparam int     SETTLE_CYCLES = 15 * MAX_OCTAVES_DEF + 60;
    localparam int     PHASES        = 9;
    localparam int     PHASE_ITEMS   = 125;
    localparam longint CYCLE_LIMIT   = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = ACT_LOAD;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_OCTAVE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [NOISE_W-1:0]    m_tdata;
    logic                  cfg_ready;
    int                    failures;
    int                    outstanding;
    bit                    steady = 1'b0;
    longint                cycles = 0;

    gradient_noise_2d_octaves dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gn2o_noise_checker noise_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("gradient_noise_2d_octaves verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_item(input logic act, input logic [7:0] idx, input logic [7:0] val,
                             input logic [15:0] x, input logic [15:0] y);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {y, x, val, idx};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic evaluate(input logic [15:0] x, input logic [15:0] y);
        send_item(ACT_EVAL, 8'($urandom), 8'($urandom), x, y);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // A load ends without a result, so the block may still be busy after the last
    // result; the settle time covers the longest evaluation.
    task automatic reconfigure(input logic [COUNT_W-1:0] oct, input logic [FREQ_W-1:0] fq);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_OCTAVE_COUNT, {12'($urandom), oct});
        write_reg(CFG_BASE_FREQ, fq);
    endtask

    logic [7:0]     shuffle [0:TABLE_SIZE-1];
    logic [7:0]     swap;
    int             j;
    logic [3:0]     oct;
    logic [15:0]    fq;
    logic [15:0]    rx;
    logic [15:0]    ry;

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            shuffle[i] = 8'(i);
        end
        for (int i = TABLE_SIZE - 1; i > 0; i--)
        begin
            j          = $urandom_range(0, i);
            swap       = shuffle[i];
            shuffle[i] = shuffle[j];
            shuffle[j] = swap;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            send_item(ACT_LOAD, 8'(i), shuffle[i], 16'($urandom), 16'($urandom));
        end

        evaluate(16'h0000, 16'h0000);
        evaluate(16'h7FFF, 16'h7FFF);
        evaluate(16'h8000, 16'h8000);
        evaluate(16'h7FFF, 16'h8000);
        evaluate(16'h8000, 16'h7FFF);
        evaluate(16'hFFFF, 16'hFFFF);
        evaluate(16'h0001, 16'h0001);
        evaluate(16'h0080, 16'hFF80);

        reconfigure(4'd8, 16'hFFFF);
        evaluate(16'h7FFF, 16'h8000);
        evaluate(16'h8000, 16'h7FFF);
        evaluate(16'h1234, 16'hFEDC);

        // Octave count zero behaves as one.
        reconfigure(4'd0, 16'h0001);
        evaluate(16'h7FFF, 16'h7FFF);
        evaluate(16'h8000, 16'h8000);

        // Counts above the maximum clip to it, and a zero frequency gives zero noise.
        reconfigure(4'd15, 16'h0000);
        evaluate(16'h7FFF, 16'h7FFF);
        evaluate(16'hFF80, 16'h0080);

        // Writes to unused register indexes must leave the configuration alone.
        reconfigure(4'd3, 16'h1000);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        write_reg(CFG_SPARE_B, 16'hFFFF);
        evaluate(16'h1357, 16'h2468);
        send_item(ACT_LOAD, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF);
        evaluate(16'hFF00, 16'h00FF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                oct = 4'd1;
                fq  = 16'hFFFF;
            end
            else if (phase == 1)
            begin
                oct = 4'd8;
                fq  = 16'h0001;
            end
            else
            begin
                oct = 4'($urandom_range(0, 15));
                fq  = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
            end
            reconfigure(oct, fq);
            if (phase == 4)
            begin
                write_reg(CFG_SPARE_A, 16'($urandom));
            end
            steady = (phase == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 5 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(ACT_LOAD, 8'($urandom), 8'($urandom),
                              16'($urandom), 16'($urandom));
                end
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        rx = 16'($urandom_range(0, 2047)) - 16'd1024;
                        ry = 16'($urandom_range(0, 2047)) - 16'd1024;
                    end
                    else
                    begin
                        rx = 16'($urandom);
                        ry = 16'($urandom);
                    end
                    evaluate(rx, ry);
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("gradient_noise_2d_octaves verification clean");
        end
        else
        begin
            $display("gradient_noise_2d_octaves verification failed");
        end
        $finish;
    end

endmodule
